FILE: hdl/bcmb_pkg.sv
// Shared types and constants for the BGR555 color math blend block.
// No dependencies.
`default_nettype none
package bcmb_pkg;

  localparam int COLOR_W  = 15;
  localparam int CH_W     = 5;
  localparam int COMP_W   = 8;
  localparam int BRIGHT_W = 4;
  localparam int MODE_W   = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 15;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_MATH_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_USE_SUB    = 2'd1;
  localparam int MODE_HALF_BIT = 0;
  localparam int MODE_SUB_BIT  = 1;
  localparam logic [CFG_IDX_W-1:0] REG_FIXED      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 2'd3;

  localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 4'd15;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [MODE_W-1:0]     math_mode;
    logic                  use_sub_screen;
    logic [COLOR_W-1:0]    fixed_color;
    logic [BRIGHT_W-1:0]   brightness;
  } cfg_t;

  // Classified pixel as handed from front to back
  typedef struct packed {
    logic [COLOR_W-1:0] main_pix;
    logic [COLOR_W-1:0] operand;
    logic               subtract;
    logic               half;
    logic               enable;
  } job_t;

  typedef struct packed {
    logic [COMP_W-1:0]  blue_out;
    logic [COMP_W-1:0]  green_out;
    logic [COMP_W-1:0]  red_out;
    logic [COLOR_W-1:0] blended_color;
  } result_t;

endpackage
`default_nettype wire

FILE: hdl/bcmb_front.sv
// Front stage: takes input beats, selects the second operand and math flags.
// Depends on bcmb_pkg.
`default_nettype none
module bcmb_front import bcmb_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cfg_t               cfg,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [COLOR_W-1:0] main_pix,
  input  wire logic [COLOR_W-1:0] sub_pix,
  input  wire logic               sub_is_backdrop,
  input  wire logic               math_enable,
  output logic                    push,
  input  wire logic               queue_full,
  output job_t                    job
);

  logic held;
  job_t job_next;

  assign push     = held && !queue_full;
  assign in_ready = !held || !queue_full;

  always_comb begin
    job_next.main_pix   = main_pix;
    job_next.operand    = cfg.use_sub_screen ? sub_pix : cfg.fixed_color;
    job_next.subtract   = cfg.math_mode[MODE_SUB_BIT];
    // backdrop under sub-screen math never halves
    job_next.half       = cfg.math_mode[MODE_HALF_BIT] &&
                          !(cfg.use_sub_screen && sub_is_backdrop);
    job_next.enable     = math_enable;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      job <= job_next;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/bcmb_queue.sv
// Short register queue that decouples the front and back stages.
// Depends on bcmb_pkg.
`default_nettype none
module bcmb_queue import bcmb_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  output logic      full,
  input  wire logic pop,
  output logic      empty,
  output job_t      head
);

  job_t                slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_CW-1:0] count;

  assign full  = (count == QUEUE_CW'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= QUEUE_CW'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    empty |-> !pop)
    else $error("pop from empty queue");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count did not advance on push");

endmodule
`default_nettype wire

FILE: hdl/bcmb_back.sv
// Back stage: per-channel add/subtract with clamp, halving, brightness scale.
// Depends on bcmb_pkg.
`default_nettype none
module bcmb_back import bcmb_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [BRIGHT_W-1:0] brightness,
  input  wire logic                queue_empty,
  input  wire job_t                head,
  output logic                     pop,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output result_t                  result
);

  function automatic logic [CH_W-1:0] blend_ch(input logic [CH_W-1:0] a,
                                               input logic [CH_W-1:0] b,
                                               input logic sub, input logic half);
    logic [CH_W:0]   sum;
    logic [CH_W-1:0] diff;
    logic [CH_W-1:0] r;
    sum  = {1'b0, a} + {1'b0, b};
    diff = (a > b) ? a - b : '0;
    if (sub) begin
      r = half ? (diff >> 1) : diff;
    end else if (half) begin
      r = sum[CH_W:1];
    end else begin
      r = sum[CH_W] ? '1 : sum[CH_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [COMP_W-1:0] scale_ch(input logic [CH_W-1:0] c,
                                                 input logic [BRIGHT_W-1:0] br);
    logic [BRIGHT_W:0]      factor;
    logic [CH_W+BRIGHT_W:0] prod;
    factor = {1'b0, br} + 1'b1;
    prod   = {{(BRIGHT_W+1){1'b0}}, c} * {{CH_W{1'b0}}, factor};
    return prod[COMP_W:1];
  endfunction

  logic [COLOR_W-1:0] color;
  result_t            result_next;

  assign pop = !queue_empty && (!out_valid || out_ready);

  always_comb begin
    color = head.main_pix;
    if (head.enable) begin
      for (int i = 0; i < 3; i++) begin
        color[i*CH_W +: CH_W] = blend_ch(head.main_pix[i*CH_W +: CH_W],
                                         head.operand[i*CH_W +: CH_W],
                                         head.subtract, head.half);
      end
    end
    result_next.blended_color = color;
    result_next.red_out       = scale_ch(color[0 +: CH_W], brightness);
    result_next.green_out     = scale_ch(color[CH_W +: CH_W], brightness);
    result_next.blue_out      = scale_ch(color[2*CH_W +: CH_W], brightness);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= !queue_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result <= result_next;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/bgr555_color_math_blend.sv
// Top level of the BGR555 color math blend block: config registers,
// front stage, queue and back stage. Depends on bcmb_pkg and its submodules.
//
//  channel   dir  handshake           payload
//  s_axis    in   s_tvalid/s_tready   tdata main+sub color, tuser flags
//  m_axis    out  m_tvalid/m_tready   tdata blended color + RGB components
//  cfg       in   cfg_we              cfg_index, cfg_data
//
// One pixel per clock sustained while m_tready stays high; a pixel passes the
// front register, then a queue slot, then the back output register.
// The two-entry queue absorbs output stalls so the front keeps accepting
// until the queue and front register are both full.
// Synchronous active-high reset empties all stages and loads register
// defaults (brightness 15, all others 0).
`default_nettype none
module bgr555_color_math_blend import bcmb_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // tdata: [14:0] main_pix, [29:15] sub_pix, [31:30] zero
  input  wire logic [31:0]           s_tdata,
  // tuser: [0] sub_is_backdrop, [1] math_enable
  input  wire logic [1:0]            s_tuser,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // tdata: [14:0] blended_color, [22:15] red_out, [30:23] green_out,
  //        [38:31] blue_out, [39] zero
  output logic [39:0]                m_tdata,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t    cfg;
  job_t    front_job;
  job_t    head;
  logic    push;
  logic    pop;
  logic    q_full;
  logic    q_empty;
  result_t result;

  // Config registers; the user must write them only while the block is idle (not enforced here)
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.math_mode      <= '0;
      cfg.use_sub_screen <= 1'b0;
      cfg.fixed_color    <= '0;
      cfg.brightness     <= BRIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MATH_MODE:  cfg.math_mode      <= cfg_data[MODE_W-1:0];
        REG_USE_SUB:    cfg.use_sub_screen <= cfg_data[0];
        REG_FIXED:      cfg.fixed_color    <= cfg_data[COLOR_W-1:0];
        REG_BRIGHTNESS: cfg.brightness     <= cfg_data[BRIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  bcmb_front u_front (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .in_valid        (s_tvalid),
    .in_ready        (s_tready),
    .main_pix        (s_tdata[COLOR_W-1:0]),
    .sub_pix         (s_tdata[2*COLOR_W-1:COLOR_W]),
    .sub_is_backdrop (s_tuser[0]),
    .math_enable     (s_tuser[1]),
    .push            (push),
    .queue_full      (q_full),
    .job             (front_job)
  );

  bcmb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (front_job),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head     (head)
  );

  bcmb_back u_back (
    .clk         (clk),
    .rst         (rst),
    .brightness  (cfg.brightness),
    .queue_empty (q_empty),
    .head        (head),
    .pop         (pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .result      (result)
  );

  assign m_tdata = {1'b0, result};

endmodule
`default_nettype wire

FILE: tb/bgr555_color_math_blend_tb.sv
`timescale 1ns / 1ps
// Testbench for bgr555_color_math_blend: directed and random pixel beats, checked
// against a per-pixel color math predictor held in a small scoreboard class.
// Depends on bcmb_pkg and the block's RTL.
module bgr555_color_math_blend_tb import bcmb_pkg::*; ();

  localparam int QUIET_LIMIT  = 3000;  // cycles with no beat on either side
  localparam int DRAIN_CYCLES = 6;     // settle time once every expected result is out
  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off

  // Scoreboard: mirror of the config registers plus the expected result beats
  class blend_scoreboard;
    cfg_t    regs;
    result_t pixels_due[$];
    int      errors;

    function new();
      regs.math_mode      = '0;
      regs.use_sub_screen = 1'b0;
      regs.fixed_color    = '0;
      regs.brightness     = BRIGHT_RESET;
      errors              = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_MATH_MODE:  regs.math_mode      = data[MODE_W-1:0];
        REG_USE_SUB:    regs.use_sub_screen = data[0];
        REG_FIXED:      regs.fixed_color    = data[COLOR_W-1:0];
        REG_BRIGHTNESS: regs.brightness     = data[BRIGHT_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [COMP_W-1:0] scale(logic [CH_W-1:0] c);
      int prod;
      prod = int'(c) * (int'(regs.brightness) + 1);
      return COMP_W'(prod >> 1);
    endfunction

    function result_t blend(logic [COLOR_W-1:0] main_c, logic [COLOR_W-1:0] sub_c,
                            logic backdrop, logic enable);
      result_t            r;
      logic [COLOR_W-1:0] op;
      logic [COLOR_W-1:0] mix;
      logic               do_sub;
      logic               do_half;
      int                 a;
      int                 b;
      int                 v;
      mix = main_c;
      if (enable) begin
        op      = regs.use_sub_screen ? sub_c : regs.fixed_color;
        do_sub  = regs.math_mode[MODE_SUB_BIT];
        // backdrop on the sub screen skips halving
        do_half = regs.math_mode[MODE_HALF_BIT] && !(regs.use_sub_screen && backdrop);
        for (int ch = 0; ch < 3; ch++) begin
          a = int'(main_c[ch*CH_W +: CH_W]);
          b = int'(op[ch*CH_W +: CH_W]);
          if (do_sub) v = (a > b) ? a - b : 0;
          else        v = a + b;
          if (do_half)     v = v >> 1;
          else if (v > 31) v = 31;
          mix[ch*CH_W +: CH_W] = CH_W'(v);
        end
      end
      r.blended_color = mix;
      r.red_out       = scale(mix[4:0]);
      r.green_out     = scale(mix[9:5]);
      r.blue_out      = scale(mix[14:10]);
      return r;
    endfunction

    function void note_pixel(logic [COLOR_W-1:0] main_c, logic [COLOR_W-1:0] sub_c,
                             logic backdrop, logic enable);
      pixels_due.push_back(blend(main_c, sub_c, backdrop, enable));
    endfunction

    function void check_pixel(logic [39:0] beat);
      result_t want;
      result_t got;
      got = result_t'(beat[38:0]);
      if (pixels_due.size() == 0) begin
        $error("unexpected result beat %h", beat);
        errors++;
        return;
      end
      want = pixels_due.pop_front();
      if (got.blended_color !== want.blended_color) begin
        $error("blended_color: expected %h, got %h", want.blended_color, got.blended_color);
        errors++;
      end
      if (got.red_out !== want.red_out) begin
        $error("red_out: expected %0d, got %0d", want.red_out, got.red_out);
        errors++;
      end
      if (got.green_out !== want.green_out) begin
        $error("green_out: expected %0d, got %0d", want.green_out, got.green_out);
        errors++;
      end
      if (got.blue_out !== want.blue_out) begin
        $error("blue_out: expected %0d, got %0d", want.blue_out, got.blue_out);
        errors++;
      end
    endfunction

    function int pending();
      return pixels_due.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [31:0]           s_tdata;
  logic [1:0]            s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [39:0]           m_tdata;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  blend_scoreboard sb = new();

  // idling knobs, percent of cycles
  int idle_pct  = 0;
  int stall_pct = 0;
  int hold_len  = 0;   // request for a receiver hold-off, picked up by that process

  bgr555_color_math_blend dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Receiver: random stalls, or a long hold-off counted down here
  initial begin : receiver
    int hold_cnt;
    hold_cnt = 0;
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        hold_cnt = hold_len;
        hold_len = 0;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Output monitor: every accepted result beat goes to the scoreboard
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_pixel(m_tdata);
  end

  // Watchdog: too long without any beat ends the run
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  // Offer one pixel beat, with random idle cycles first, and hold it until taken
  task automatic send_pixel(logic [COLOR_W-1:0] main_c, logic [COLOR_W-1:0] sub_c,
                            logic backdrop, logic enable);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, sub_c, main_c};
    s_tuser  <= {enable, backdrop};
    do @(posedge clk); while (!s_tready);
    sb.note_pixel(main_c, sub_c, backdrop, enable);
  endtask

  // Drop valid, wait until every expected result is out, then wait DRAIN_CYCLES more
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Back-to-back register writes; cfg_we drops only after the last one
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  // Load all four registers while idle; unused high data bits carry junk
  task automatic set_config(logic [MODE_W-1:0] mode, logic use_sub,
                            logic [COLOR_W-1:0] fixed_c, logic [BRIGHT_W-1:0] bright);
    logic [CFG_DATA_W-1:0] junk;
    drain();
    junk = CFG_DATA_W'($urandom);
    write_reg(REG_MATH_MODE, {junk[CFG_DATA_W-1:MODE_W], mode});
    junk = CFG_DATA_W'($urandom);
    write_reg(REG_USE_SUB, {junk[CFG_DATA_W-1:1], use_sub});
    write_reg(REG_FIXED, fixed_c);
    junk = CFG_DATA_W'($urandom);
    write_reg(REG_BRIGHTNESS, {junk[CFG_DATA_W-1:BRIGHT_W], bright});
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Channel value biased toward the saturation and clamp edges
  function automatic logic [CH_W-1:0] edge_chan();
    case ($urandom_range(5))
      0: return 5'd0;
      1: return 5'd1;
      2: return 5'd15;
      3: return 5'd16;
      4: return 5'd30;
      default: return 5'd31;
    endcase
  endfunction

  function automatic logic [COLOR_W-1:0] rand_color();
    if ($urandom_range(9) < 6) return COLOR_W'($urandom);
    return {edge_chan(), edge_chan(), edge_chan()};
  endfunction

  task automatic send_random_pixel();
    send_pixel(rand_color(), rand_color(), 1'($urandom_range(1)),
               ($urandom_range(99) < 75));
  endtask

  initial begin : stimulus
    logic [MODE_W-1:0]   mode;
    logic                use_sub;
    logic [COLOR_W-1:0]  fixed_c;
    logic [BRIGHT_W-1:0] bright;
    int                  idle_sel;

    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed part, reset config first: add with fixed color 0, full brightness
    send_pixel(15'h0000, 15'h7fff, 1'b1, 1'b0);   // math off, black
    send_pixel(15'h7fff, 15'h0000, 1'b0, 1'b0);   // math off, white still scaled
    send_pixel(15'h7fff, 15'h7fff, 1'b0, 1'b1);

    // add with sub screen: saturation
    set_config(2'd0, 1'b1, 15'h0000, 4'd15);
    send_pixel(15'h7fff, 15'h7fff, 1'b0, 1'b1);
    send_pixel(15'h5ad6, 15'h2529, 1'b0, 1'b1);

    // half add: backdrop skips the halving
    set_config(2'd1, 1'b1, 15'h0000, 4'd15);
    send_pixel(15'h7fff, 15'h7fff, 1'b0, 1'b1);
    send_pixel(15'h7fff, 15'h7fff, 1'b1, 1'b1);
    send_pixel(15'h4210, 15'h0421, 1'b0, 1'b1);

    // subtract: clamp at zero
    set_config(2'd2, 1'b1, 15'h0000, 4'd7);
    send_pixel(15'h0000, 15'h7fff, 1'b0, 1'b1);
    send_pixel(15'h7fff, 15'h0000, 1'b0, 1'b1);
    send_pixel(15'h7fff, 15'h7fff, 1'b1, 1'b1);

    // half subtract at brightness 0
    set_config(2'd3, 1'b1, 15'h0000, 4'd0);
    send_pixel(15'h7fff, 15'h0000, 1'b0, 1'b1);
    send_pixel(15'h7fff, 15'h0000, 1'b1, 1'b1);

    // fixed color math: backdrop flag and sub color have no say
    set_config(2'd1, 1'b0, 15'h7fff, 4'd15);
    send_pixel(15'h7fff, 15'h0000, 1'b1, 1'b1);
    send_pixel(15'h0000, 15'h7fff, 1'b1, 1'b1);

    set_config(2'd2, 1'b0, 15'h2108, 4'd1);
    send_pixel(15'h7fff, 15'h1234, 1'b0, 1'b1);
    send_pixel(15'h0421, 15'h7fff, 1'b1, 1'b1);
    send_pixel(15'h7fff, 15'h5555, 1'b0, 1'b0);

    // --- random part: eight phases, every mode with both operand sources
    for (int p = 0; p < 8; p++) begin
      mode    = MODE_W'(p % 4);
      use_sub = (p >= 4);
      case (p % 3)
        0:       fixed_c = 15'h7fff;
        1:       fixed_c = 15'h0000;
        default: fixed_c = COLOR_W'($urandom);
      endcase
      case (p % 4)
        1:       bright = 4'd0;
        3:       bright = 4'd15;
        default: bright = BRIGHT_W'($urandom);
      endcase
      set_config(mode, use_sub, fixed_c, bright);

      idle_sel = (p + p / 4) % 4;
      case (idle_sel)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 67; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 67; end
        default: begin idle_pct = 28; stall_pct = 28; end
      endcase

      // back pressure: receiver holds off while the sender keeps offering
      if (p == 0) hold_len = HOLD_CYCLES;

      for (int i = 0; i < 80; i++) begin
        // sender pause until the pipe is empty, mid phase
        if (p == 5 && i == 40) drain();
        send_random_pixel();
      end
    end

    idle_pct  = 0;
    stall_pct = 0;
    drain();

    if (sb.errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

FILE: sim.f
hdl/bcmb_pkg.sv
hdl/bcmb_front.sv
hdl/bcmb_queue.sv
hdl/bcmb_back.sv
hdl/bgr555_color_math_blend.sv
tb/bgr555_color_math_blend_tb.sv
